// ----- src/max_pool_2d_stream_defines.svh -----
// Assertion helpers shared by the max pooling block.
`ifndef MAX_POOL_2D_STREAM_DEFINES_SVH
`define MAX_POOL_2D_STREAM_DEFINES_SVH

// Same-cycle implication, checked on every clock out of reset.
`define MP2D_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("max_pool_2d_stream: check failed");

// Next-cycle implication.
`define MP2D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("max_pool_2d_stream: check failed");

`endif

// ----- src/mp2d_pkg.sv -----
package mp2d_pkg;

    localparam int DATA_W      = 16;
    localparam int ROW_W       = 10;
    localparam int COL_W       = 8;
    localparam int CH_W        = 5;
    localparam int POS_W       = 10;
    localparam int Q_W         = 11;
    localparam int WIN_MAX     = 8;
    localparam int M_W         = 3;
    localparam int SLOT_W      = 3;
    localparam int ADDR_W      = SLOT_W + COL_W + CH_W;
    localparam int RAM_DEPTH   = 1 << ADDR_W;
    localparam int MAX_DIM     = 1024;
    localparam int MAX_OUT_W   = 256;
    localparam int MAX_CH      = 32;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_HEIGHT   = 4'd0,
        REG_IN_WIDTH    = 4'd1,
        REG_CHANNELS    = 4'd2,
        REG_WINDOW_SIZE = 4'd3,
        REG_STEP        = 4'd4,
        REG_PAD_AMOUNT  = 4'd5,
        REG_OUT_HEIGHT  = 4'd6,
        REG_OUT_WIDTH   = 4'd7
    } t_reg_idx;

    // One accepted element with the window offsets it touches.
    // Offset m selects output row q_row - m, offset n output column q_col - n.
    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic [CH_W-1:0]          chan;
        logic [Q_W-1:0]           q_row;
        logic [Q_W-1:0]           q_col;
        logic [M_W-1:0]           m_hi;
        logic [M_W-1:0]           m_lo;
        logic [M_W-1:0]           n_hi;
        logic [M_W-1:0]           n_lo;
        logic [M_W-1:0]           m_fin;
        logic [M_W-1:0]           n_fin;
        logic [WIN_MAX-1:0]       first_r;
        logic [WIN_MAX-1:0]       last_r;
        logic [WIN_MAX-1:0]       first_c;
        logic [WIN_MAX-1:0]       last_c;
    } t_job;

endpackage

// ----- src/mp2d_ram.sv -----
module mp2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- src/mp2d_front.sv -----
module mp2d_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [mp2d_pkg::DATA_W-1:0] i_sample,
    input  logic                             i_q_full,
    output logic                             o_push,
    output mp2d_pkg::t_job                   o_job
);
    import mp2d_pkg::*;

    logic [10:0] r_in_height, r_in_width, r_out_height;
    logic [5:0]  r_channels;
    logic [3:0]  r_window_size, r_step;
    logic [2:0]  r_pad_amount;
    logic [8:0]  r_out_width;

    logic [POS_W-1:0] r_row, r_col;
    logic [CH_W-1:0]  r_chan;
    logic [3:0]       r_rem_r, r_rem_c;
    logic [Q_W-1:0]   r_q_r, r_q_c;
    logic             r_init;

    logic [10:0] h_eff, w_eff, oh_eff, ow_eff;
    logic [5:0]  c_eff;
    logic [3:0]  s_eff, st_eff;
    logic [1:0]  hp;
    logic [5:0]  st1, st2, st3, hp6, sub;
    logic [1:0]  q0;
    logic [3:0]  rem0;
    logic [6:0]  s_m1;
    logic [WIN_MAX-1:0] vr, vc, fr, fc, lr, lc;
    logic [M_W-1:0] m_hi, m_lo, n_hi, n_lo, m_fin, n_fin;
    logic        accept;
    logic [3:0]  rem_r_inc, rem_c_inc;

    always_comb begin
        h_eff  = (r_in_height == '0) ? 11'd1 :
                 (r_in_height > 11'(MAX_DIM)) ? 11'(MAX_DIM) : r_in_height;
        w_eff  = (r_in_width == '0) ? 11'd1 :
                 (r_in_width > 11'(MAX_DIM)) ? 11'(MAX_DIM) : r_in_width;
        c_eff  = (r_channels == '0) ? 6'd1 :
                 (r_channels > 6'(MAX_CH)) ? 6'(MAX_CH) : r_channels;
        s_eff  = (r_window_size == '0) ? 4'd1 :
                 (r_window_size > 4'(WIN_MAX)) ? 4'(WIN_MAX) : r_window_size;
        st_eff = (r_step == '0) ? 4'd1 : r_step;
        hp     = r_pad_amount[2:1];
        oh_eff = (r_out_height > 11'(MAX_DIM)) ? 11'(MAX_DIM) : r_out_height;
        ow_eff = (r_out_width > 9'(MAX_OUT_W)) ? 11'(MAX_OUT_W) : 11'(r_out_width);
        s_m1   = 7'(s_eff) - 7'd1;

        // phase of the first row/column: hp / step and hp % step, hp <= 3
        st1 = 6'(st_eff);
        st2 = st1 + st1;
        st3 = st2 + st1;
        hp6 = 6'(hp);
        if (hp6 >= st3) begin
            q0 = 2'd3; sub = st3;
        end else if (hp6 >= st2) begin
            q0 = 2'd2; sub = st2;
        end else if (hp6 >= st1) begin
            q0 = 2'd1; sub = st1;
        end else begin
            q0 = 2'd0; sub = '0;
        end
        rem0 = 4'(hp6 - sub);
    end

    // per offset: does the window cover this element, does it open or close here
    always_comb begin
        logic [6:0] d_r, d_c;
        for (int m = 0; m < WIN_MAX; m++) begin
            d_r = 7'(r_rem_r) + 7'(m) * 7'(st_eff);
            d_c = 7'(r_rem_c) + 7'(m) * 7'(st_eff);
            vr[m] = (d_r <= s_m1) && (11'(m) <= r_q_r) && ((r_q_r - 11'(m)) < oh_eff);
            vc[m] = (d_c <= s_m1) && (11'(m) <= r_q_c) && ((r_q_c - 11'(m)) < ow_eff);
            fr[m] = (r_row == '0) || (d_r == '0);
            fc[m] = (r_col == '0) || (d_c == '0);
            lr[m] = (11'(r_row) == h_eff - 11'd1) || (d_r == s_m1);
            lc[m] = (11'(r_col) == w_eff - 11'd1) || (d_c == s_m1);
        end
    end

    always_comb begin
        m_hi = '0; n_hi = '0; m_lo = '0; n_lo = '0; m_fin = '0; n_fin = '0;
        for (int m = 0; m < WIN_MAX; m++) begin
            if (vr[m]) m_hi = M_W'(m);
            if (vc[m]) n_hi = M_W'(m);
        end
        for (int m = WIN_MAX - 1; m >= 0; m--) begin
            if (vr[m]) m_lo = M_W'(m);
            if (vc[m]) n_lo = M_W'(m);
            if (vr[m] && lr[m]) m_fin = M_W'(m);
            if (vc[m] && lc[m]) n_fin = M_W'(m);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_full && !r_init;
    assign accept      = i_in_valid && o_in_ready;
    assign o_push      = accept && (|vr) && (|vc);
    assign rem_r_inc   = r_rem_r + 4'd1;
    assign rem_c_inc   = r_rem_c + 4'd1;

    always_comb begin
        o_job.sample  = i_sample;
        o_job.chan    = r_chan;
        o_job.q_row   = r_q_r;
        o_job.q_col   = r_q_c;
        o_job.m_hi    = m_hi;
        o_job.m_lo    = m_lo;
        o_job.n_hi    = n_hi;
        o_job.n_lo    = n_lo;
        o_job.m_fin   = m_fin;
        o_job.n_fin   = n_fin;
        o_job.first_r = fr;
        o_job.last_r  = lr;
        o_job.first_c = fc;
        o_job.last_c  = lc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_height   <= 11'd2;
            r_in_width    <= 11'd2;
            r_channels    <= 6'd1;
            r_window_size <= 4'd2;
            r_step        <= 4'd2;
            r_pad_amount  <= 3'd0;
            r_out_height  <= 11'd1;
            r_out_width   <= 9'd1;
            r_row  <= '0;
            r_col  <= '0;
            r_chan <= '0;
            r_init <= 1'b1;
        end else if (i_cfg_valid && i_cfg_index < CFG_IDX_W'(8)) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_IN_HEIGHT:   r_in_height   <= i_cfg_data;
                REG_IN_WIDTH:    r_in_width    <= i_cfg_data;
                REG_CHANNELS:    r_channels    <= i_cfg_data[5:0];
                REG_WINDOW_SIZE: r_window_size <= i_cfg_data[3:0];
                REG_STEP:        r_step        <= i_cfg_data[3:0];
                REG_PAD_AMOUNT:  r_pad_amount  <= i_cfg_data[2:0];
                REG_OUT_HEIGHT:  r_out_height  <= i_cfg_data;
                REG_OUT_WIDTH:   r_out_width   <= i_cfg_data[8:0];
                default: ;
            endcase
            r_row  <= '0;
            r_col  <= '0;
            r_chan <= '0;
            r_init <= 1'b1;
        end else if (r_init) begin
            // phases reload from the settled registers while r_init is set, before input is taken
            r_rem_r <= rem0;
            r_rem_c <= rem0;
            r_q_r   <= Q_W'(q0);
            r_q_c   <= Q_W'(q0);
            r_init  <= 1'b0;
        end else if (accept) begin
            if (6'(r_chan) == c_eff - 6'd1) begin
                r_chan <= '0;
                if (11'(r_col) == w_eff - 11'd1) begin
                    r_col   <= '0;
                    r_rem_c <= rem0;
                    r_q_c   <= Q_W'(q0);
                    if (11'(r_row) == h_eff - 11'd1) begin
                        r_row   <= '0;
                        r_rem_r <= rem0;
                        r_q_r   <= Q_W'(q0);
                    end else begin
                        r_row <= r_row + 1'b1;
                        if (rem_r_inc == st_eff) begin
                            r_rem_r <= '0;
                            r_q_r   <= r_q_r + 1'b1;
                        end else begin
                            r_rem_r <= rem_r_inc;
                        end
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                    if (rem_c_inc == st_eff) begin
                        r_rem_c <= '0;
                        r_q_c   <= r_q_c + 1'b1;
                    end else begin
                        r_rem_c <= rem_c_inc;
                    end
                end
            end else begin
                r_chan <= r_chan + 1'b1;
            end
        end
    end

endmodule

// ----- src/mp2d_queue.sv -----
`include "max_pool_2d_stream_defines.svh"

module mp2d_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mp2d_pkg::t_job i_job,
    input  logic           i_pop,
    output mp2d_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);
    import mp2d_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `MP2D_ASSERT_IMPL(a_q_count_bound, 1'b1, r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
    `MP2D_ASSERT_IMPL(a_q_pop_nonempty, i_pop, r_count != '0)

endmodule

// ----- src/mp2d_back.sv -----
`include "max_pool_2d_stream_defines.svh"

module mp2d_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    input  mp2d_pkg::t_job                   i_job,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [mp2d_pkg::DATA_W-1:0] o_pooled_value,
    output logic [mp2d_pkg::ROW_W-1:0]       o_out_row,
    output logic [mp2d_pkg::COL_W-1:0]       o_out_col,
    output logic [mp2d_pkg::CH_W-1:0]        o_out_channel,
    output logic                             o_run_last
);
    import mp2d_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_UPD} t_state;

    t_state             r_state;
    t_job               r_job;
    logic [M_W-1:0]     r_m, r_n;
    logic [Q_W-1:0]     row_idx, col_idx;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  rd_data;
    logic signed [DATA_W-1:0] cur_max;
    logic               is_first, is_last, out_free, go;

    assign row_idx  = r_job.q_row - Q_W'(r_m);
    assign col_idx  = r_job.q_col - Q_W'(r_n);
    // slot = output row mod 8; at most eight window rows are open at once
    assign addr     = {row_idx[SLOT_W-1:0], col_idx[COL_W-1:0], r_job.chan};
    assign is_first = r_job.first_r[r_m] && r_job.first_c[r_n];
    assign is_last  = r_job.last_r[r_m] && r_job.last_c[r_n];
    assign cur_max  = (is_first || (r_job.sample > $signed(rd_data))) ?
                      r_job.sample : $signed(rd_data);
    assign out_free = !o_out_valid || i_out_ready;
    assign go       = (r_state == ST_UPD) && (!is_last || out_free);
    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty;

    mp2d_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_max_ram (
        .i_clk     (i_clk),
        .i_wr_en   (go),
        .i_wr_addr (addr),
        .i_wr_data (cur_max),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (go && is_last) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_job   <= i_job;
                        r_m     <= i_job.m_hi;
                        r_n     <= i_job.n_hi;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: r_state <= ST_UPD;
                ST_UPD: begin
                    if (go) begin
                        if (is_last) begin
                            o_pooled_value <= cur_max;
                            o_out_row      <= row_idx[ROW_W-1:0];
                            o_out_col      <= col_idx[COL_W-1:0];
                            o_out_channel  <= r_job.chan;
                            o_run_last     <= (r_m == r_job.m_fin) && (r_n == r_job.n_fin);
                        end
                        // rows ascend as m falls, columns ascend as n falls
                        if (r_n != r_job.n_lo) begin
                            r_n     <= r_n - 1'b1;
                            r_state <= ST_READ;
                        end else if (r_m != r_job.m_lo) begin
                            r_m     <= r_m - 1'b1;
                            r_n     <= r_job.n_hi;
                            r_state <= ST_READ;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `MP2D_ASSERT_NEXT(a_bk_stall_holds, r_state == ST_UPD && is_last && !out_free, r_state == ST_UPD)
    `MP2D_ASSERT_NEXT(a_bk_result_out, go && is_last, o_out_valid)
    `MP2D_ASSERT_IMPL(a_bk_offset_range, r_state != ST_IDLE, r_m >= r_job.m_lo && r_m <= r_job.m_hi && r_n >= r_job.n_lo && r_n <= r_job.n_hi)

endmodule

// ----- src/max_pool_2d_stream.sv -----
// Streaming 2-D max pooling, signed Q8.8 data.
// Input channel (i_in_valid/o_in_ready, i_sample): elements in row, column,
// channel order, image after image. Output channel (o_out_valid/i_out_ready):
// one item per closed window with its maximum, output row, column, channel;
// o_run_last marks the last item caused by one input element.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data): always
// ready; a write to index 0..7 restarts the scan at row 0, column 0, channel 0
// and holds off input while the phases reload. Write only while the block is idle.
// Throughput: the front takes one element per cycle into a 4-entry queue while
// it is not full; the back pops one element and, for each window it touches,
// reads and then compares and writes the running-max RAM, taking no new
// element until the last of those windows is done. When the receiver stalls,
// the output register holds, the back waits on a closing window and the queue
// fills before o_in_ready drops.
// Reset: registers take their defaults, position returns to the origin; the RAM
// is not cleared, since every window loads its first element.
module max_pool_2d_stream (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [mp2d_pkg::DATA_W-1:0] i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [mp2d_pkg::DATA_W-1:0] o_pooled_value,
    output logic [mp2d_pkg::ROW_W-1:0]        o_out_row,
    output logic [mp2d_pkg::COL_W-1:0]        o_out_col,
    output logic [mp2d_pkg::CH_W-1:0]         o_out_channel,
    output logic                              o_run_last
);
    import mp2d_pkg::*;

    t_job push_job, head_job;
    logic push, pop, q_full, q_empty;

    mp2d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    mp2d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mp2d_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_job          (head_job),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pooled_value (o_pooled_value),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_out_channel  (o_out_channel),
        .o_run_last     (o_run_last)
    );

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    import mp2d_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic [CH_W-1:0]          chan;
        logic                     last;
    } t_pool_res;

    // Predicts pooled windows from the accepted sample stream and checks results.
    class pool_board;
        logic [10:0] cfg [8];
        int unsigned pos_r, pos_c, pos_k;
        logic signed [DATA_W-1:0] run_max [int];
        t_pool_res pending [$];
        int errors;

        function new();
            cfg[REG_IN_HEIGHT] = 2;   cfg[REG_IN_WIDTH] = 2;  cfg[REG_CHANNELS] = 1;
            cfg[REG_WINDOW_SIZE] = 2; cfg[REG_STEP] = 2;      cfg[REG_PAD_AMOUNT] = 0;
            cfg[REG_OUT_HEIGHT] = 1;  cfg[REG_OUT_WIDTH] = 1;
            pos_r = 0; pos_c = 0; pos_k = 0; errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [10:0] data);
            logic [10:0] msk [8];
            msk = '{11'h7ff, 11'h7ff, 11'h3f, 11'hf, 11'hf, 11'h7, 11'h7ff, 11'h1ff};
            if (idx < 8) begin
                cfg[idx] = data & msk[idx];
                pos_r = 0; pos_c = 0; pos_k = 0;
            end
        endfunction

        static function int lim(int v, int lo, int hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void note_sample(logic signed [DATA_W-1:0] x);
            int h, w, nc, sz, st, hp, oh, ow, lo, ilo, ihi, jlo, jhi, si, sj, key;
            int fr, lr, fc, lc, n;
            t_pool_res rr;
            h = lim(cfg[0], 1, MAX_DIM);  w = lim(cfg[1], 1, MAX_DIM);
            nc = lim(cfg[2], 1, MAX_CH);  sz = lim(cfg[3], 1, WIN_MAX);
            st = lim(cfg[4], 1, 15);      hp = cfg[5] / 2;
            oh = lim(cfg[6], 0, MAX_DIM); ow = lim(cfg[7], 0, MAX_OUT_W);
            n = 0;
            lo = pos_r + hp - sz + 1; if (lo < 0) lo = 0;
            ilo = (lo + st - 1) / st; ihi = (pos_r + hp) / st;
            if (ihi > oh - 1) ihi = oh - 1;
            lo = pos_c + hp - sz + 1; if (lo < 0) lo = 0;
            jlo = (lo + st - 1) / st; jhi = (pos_c + hp) / st;
            if (jhi > ow - 1) jhi = ow - 1;
            for (int i = ilo; i <= ihi; i++) begin
                si = i * st - hp;
                fr = si < 0 ? 0 : si; lr = (si + sz < h ? si + sz : h) - 1;
                for (int j = jlo; j <= jhi; j++) begin
                    sj = j * st - hp;
                    fc = sj < 0 ? 0 : sj; lc = (sj + sz < w ? sj + sz : w) - 1;
                    key = ((i % WIN_MAX) * MAX_OUT_W + j) * MAX_CH + pos_k;
                    if ((pos_r == fr && pos_c == fc) || !run_max.exists(key)
                        || x > run_max[key])
                        run_max[key] = x;
                    if (pos_r == lr && pos_c == lc) begin
                        rr.value = run_max[key]; rr.row = ROW_W'(i); rr.col = COL_W'(j);
                        rr.chan = CH_W'(pos_k); rr.last = 0;
                        pending.push_back(rr); n++;
                    end
                end
            end
            if (n > 0) pending[$].last = 1;
            pos_k++;
            if (pos_k >= nc) begin
                pos_k = 0; pos_c++;
                if (pos_c >= w) begin
                    pos_c = 0; pos_r++;
                    if (pos_r >= h) pos_r = 0;
                end
            end
        endfunction

        function void check_result(t_pool_res got);
            t_pool_res e;
            if (pending.size() == 0) begin
                $error("unexpected result row %0d col %0d", got.row, got.col);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.value !== e.value) begin
                $error("pooled_value exp %0d got %0d", e.value, got.value); errors++;
            end
            if (got.row !== e.row) begin
                $error("out_row exp %0d got %0d", e.row, got.row); errors++;
            end
            if (got.col !== e.col) begin
                $error("out_col exp %0d got %0d", e.col, got.col); errors++;
            end
            if (got.chan !== e.chan) begin
                $error("out_channel exp %0d got %0d", e.chan, got.chan); errors++;
            end
            if (got.last !== e.last) begin
                $error("run_last exp %0d got %0d", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 0, o_in_ready;
    logic signed [DATA_W-1:0] i_sample = '0;
    logic o_out_valid, i_out_ready = 0;
    logic signed [DATA_W-1:0] o_pooled_value;
    logic [ROW_W-1:0] o_out_row;
    logic [COL_W-1:0] o_out_col;
    logic [CH_W-1:0] o_out_channel;
    logic o_run_last;

    pool_board board = new();
    int idle_cycles = 0;
    bit hold_recv = 0;
    bit draining = 0;

    max_pool_2d_stream DUT (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) board.note_sample(i_sample);
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result({o_pooled_value, o_out_row, o_out_col, o_out_channel,
                                o_run_last});
    end

    // Receiver: own stall pattern, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_recv) i_out_ready <= 0;
        else if (draining || $urandom_range(0, 3) != 0) i_out_ready <= 1;
        else i_out_ready <= 0;
    end

    // Watchdog on cycles with no accepted item.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || hold_recv)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic cfg_write(t_reg_idx idx, logic [10:0] data);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(logic signed [DATA_W-1:0] x, bit gaps);
        i_in_valid <= 1; i_sample <= x;
        do @(posedge i_clk); while (!o_in_ready);
        if (gaps && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        i_in_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        draining = 1;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        draining = 0;
    endtask

    task automatic set_shape(int h, int w, int c, int sz, int st, int p, int oh, int ow);
        cfg_write(REG_IN_HEIGHT, 11'(h));   cfg_write(REG_IN_WIDTH, 11'(w));
        cfg_write(REG_CHANNELS, 11'(c));    cfg_write(REG_WINDOW_SIZE, 11'(sz));
        cfg_write(REG_STEP, 11'(st));       cfg_write(REG_PAD_AMOUNT, 11'(p));
        cfg_write(REG_OUT_HEIGHT, 11'(oh)); cfg_write(REG_OUT_WIDTH, 11'(ow));
    endtask

    function automatic logic signed [DATA_W-1:0] rnd_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Image-aligned shape with random samples: windows that all touch the image.
    task automatic run_shape(int h, int w, int c, int sz, int st, int p, int imgs, bit gaps);
        int hp, oh, ow;
        hp = p / 2;
        oh = (h + hp - 1) / st + 1; ow = (w + hp - 1) / st + 1;
        if (oh * st - hp >= h) oh = oh - 1;
        if (ow * st - hp >= w) ow = ow - 1;
        if (oh < 1) oh = 1;
        if (ow < 1) ow = 1;
        set_shape(h, w, c, sz, st, p, oh, ow);
        repeat (imgs * h * w * c) send_sample(rnd_sample(), gaps);
        stop_sending();
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Reset defaults: 2x2 image, 2x2 window.
        send_sample(16'sh7fff, 0); send_sample(16'sh8000, 0);
        send_sample(16'sh0000, 0); send_sample(-16'sd1, 0);
        stop_sending(); drain();
        // Zero dimensions act as one; zero output size gives nothing.
        set_shape(0, 0, 0, 0, 0, 0, 1, 1);
        send_sample(16'sh1234, 0); send_sample(16'sh8000, 0);
        stop_sending(); drain();
        set_shape(2, 2, 1, 2, 2, 0, 0, 0);
        repeat (4) send_sample(rnd_sample(), 0);
        stop_sending(); drain();
        // Oversized window saturates; step 15 is taken as is; ignored index.
        set_shape(2, 3, 1, 15, 15, 7, 1, 1);
        i_cfg_valid <= 1; i_cfg_index <= 4'd9; i_cfg_data <= 11'h7ff;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(4'd9, 11'h7ff);
        i_cfg_valid <= 0;
        repeat (6) send_sample(rnd_sample(), 0);
        stop_sending(); drain();
        // Heavy overlap: step 1, window 8, many results per sample, receiver held.
        set_shape(8, 8, 1, 8, 1, 6, 8, 8);
        fork
            begin
                hold_recv = 1;
                repeat (300) @(posedge i_clk);
                hold_recv = 0;
            end
            begin
                repeat (64) send_sample(rnd_sample(), 0);
                stop_sending();
            end
        join
        drain();
        run_shape(3, 4, 3, 3, 2, 2, 1, 1);
        run_shape(5, 5, 2, 2, 1, 0, 1, 1);
        run_shape(4, 6, 1, 3, 3, 4, 1, 1);
        run_shape(1, 1, 32, 1, 1, 0, 1, 1);
        cfg_write(REG_IN_HEIGHT, 11'h7ff);
        cfg_write(REG_OUT_WIDTH, 9'h1ff);
        set_shape(2, 2, 1, 2, 2, 0, 1, 1);
        repeat (8) send_sample(rnd_sample(), 1);
        stop_sending(); drain();
        if (board.errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+src
src/mp2d_pkg.sv
src/mp2d_ram.sv
src/mp2d_front.sv
src/mp2d_queue.sv
src/mp2d_back.sv
src/max_pool_2d_stream.sv
tb/sv/testbench.sv
